// ===== sv/ubrf_pkg.sv =====
`timescale 1ns / 1ps

package ubrf_pkg;

   localparam int BYTE_W    = 8;
   localparam int OFF_W     = 3;
   localparam int DIV_W     = 16;
   localparam int POLL_W    = 4;
   localparam int IND_DEPTH = 256;
   localparam int IND_AW    = 8;

   localparam logic [POLL_W-1:0] POLL_LIMIT = 4'd8;
   localparam logic [POLL_W-1:0] POLL_MAX   = 4'd15;

   // access kinds
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // register offsets
   localparam logic [OFF_W-1:0] OFF_RHR_THR = 3'd0;
   localparam logic [OFF_W-1:0] OFF_IER     = 3'd1;
   localparam logic [OFF_W-1:0] OFF_FCR_EFR = 3'd2;
   localparam logic [OFF_W-1:0] OFF_LCR     = 3'd3;
   localparam logic [OFF_W-1:0] OFF_MCR     = 3'd4;
   localparam logic [OFF_W-1:0] OFF_LSR_ICR = 3'd5;
   localparam logic [OFF_W-1:0] OFF_MSR     = 3'd6;
   localparam logic [OFF_W-1:0] OFF_SPR     = 3'd7;

   localparam logic [BYTE_W-1:0] LCR_BANK_KEY = 8'hBF;
   localparam logic [BYTE_W-1:0] LCR_DLAB     = 8'h80;
   localparam logic [BYTE_W-1:0] LSR_RX_READY = 8'h61;
   localparam logic [BYTE_W-1:0] LSR_RX_EMPTY = 8'h60;
   localparam logic [BYTE_W-1:0] EFR_BAD_BITS = 8'hEF;
   localparam logic [BYTE_W-1:0] FCR_BAD_BITS = 8'hF8;
   localparam logic [BYTE_W-1:0] LCR_BAD_BITS = 8'h7C;
   localparam logic [BYTE_W-1:0] MCR_BAD_BITS = 8'hFD;
   localparam logic [DIV_W-1:0]  DIV_HI_MASK  = 16'hFF00;
   localparam logic [DIV_W-1:0]  DIV_LO_MASK  = 16'h00FF;

   localparam logic [IND_AW-1:0] ACR_INDEX = 8'd0;

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic              tx_valid;
      logic [BYTE_W-1:0] tx_byte;
      logic              rx_take;
      logic              sleep_request;
      logic              access_error;
   } rsp_type;

endpackage

// ===== sv/ubrf_if.sv =====
`timescale 1ns / 1ps

interface ubrf_req_if;
   logic                            valid;
   logic                            ready;
   logic                            cmd;
   logic [ubrf_pkg::OFF_W-1:0]      reg_offset;
   logic [ubrf_pkg::BYTE_W-1:0]     write_data;
   logic                            rx_ready;
   logic [ubrf_pkg::BYTE_W-1:0]     rx_byte;

   modport source (output valid, cmd, reg_offset, write_data, rx_ready, rx_byte,
                   input ready);
   modport sink   (input valid, cmd, reg_offset, write_data, rx_ready, rx_byte,
                   output ready);
endinterface

interface ubrf_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ubrf_pkg::BYTE_W-1:0]     read_data;
   logic                            tx_valid;
   logic [ubrf_pkg::BYTE_W-1:0]     tx_byte;
   logic                            rx_take;
   logic                            sleep_request;
   logic                            access_error;

   modport source (output valid, read_data, tx_valid, tx_byte, rx_take, sleep_request,
                   access_error, input ready);
   modport sink   (input valid, read_data, tx_valid, tx_byte, rx_take, sleep_request,
                   access_error, output ready);
endinterface

interface ubrf_csr_if;
   logic valid;
   logic ready;
   logic data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== sv/ubrf_ram.sv =====
`timescale 1ns / 1ps

module ubrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read-first: a same-cycle write is not seen
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/ubrf_core.sv =====
`timescale 1ns / 1ps

module ubrf_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_data,
   input  logic                          acc,
   input  logic                          cmd,
   input  logic [ubrf_pkg::OFF_W-1:0]    reg_offset,
   input  logic [ubrf_pkg::BYTE_W-1:0]   write_data,
   input  logic                          rx_ready,
   input  logic [ubrf_pkg::BYTE_W-1:0]   rx_byte,
   output ubrf_pkg::rsp_type             rsp
);

   logic                          clock_select_ff, clock_select_in;
   logic [ubrf_pkg::DIV_W-1:0]    divisor_ff, divisor_in;
   logic [ubrf_pkg::BYTE_W-1:0]   lcr_ff, lcr_in;
   logic [ubrf_pkg::BYTE_W-1:0]   mcr_ff, mcr_in;
   logic [ubrf_pkg::BYTE_W-1:0]   fcr_ff, fcr_in;
   logic [ubrf_pkg::BYTE_W-1:0]   efr_ff, efr_in;
   logic [ubrf_pkg::IND_AW-1:0]   spr_ff, spr_in;
   logic                          bank_ff, bank_in;
   logic [ubrf_pkg::POLL_W-1:0]   poll_ff, poll_in;
   logic [ubrf_pkg::POLL_W-1:0]   poll_cnt;
   // ACR lives in RAM entry 0: valid bit plus a registered forward path
   logic                          acr_valid_ff, acr_valid_in;
   logic                          fwd_valid_ff, fwd_valid_in;
   logic [ubrf_pkg::BYTE_W-1:0]   fwd_data_ff;
   logic                          ram_we;
   logic [ubrf_pkg::BYTE_W-1:0]   ram_q;
   logic [ubrf_pkg::BYTE_W-1:0]   acr;
   logic                          lcr7, acr7, acr6;

   ubrf_ram #(
      .WIDTH (ubrf_pkg::BYTE_W),
      .DEPTH (ubrf_pkg::IND_DEPTH)
   ) u_ind_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (spr_ff),
      .wdata (write_data),
      .raddr (ubrf_pkg::ACR_INDEX),
      .rdata (ram_q)
   );

   always_comb begin
      if (fwd_valid_ff) begin
         acr = fwd_data_ff;
      end else if (acr_valid_ff) begin
         acr = ram_q;
      end else begin
         acr = '0;
      end
   end

   assign lcr7 = lcr_ff[7];
   assign acr7 = acr[7];
   assign acr6 = acr[6];
   assign poll_cnt = (poll_ff < ubrf_pkg::POLL_MAX) ? poll_ff + 4'd1 : ubrf_pkg::POLL_MAX;

   assign clock_select_in = csr_we ? csr_data : clock_select_ff;

   always_comb begin
      divisor_in = divisor_ff;
      lcr_in     = lcr_ff;
      mcr_in     = mcr_ff;
      fcr_in     = fcr_ff;
      efr_in     = efr_ff;
      spr_in     = spr_ff;
      bank_in    = bank_ff;
      poll_in    = poll_ff;
      ram_we     = 1'b0;
      rsp        = '0;
      if (acc) begin
         poll_in = '0;
         if (cmd == ubrf_pkg::CMD_WRITE) begin
            case (reg_offset)
               ubrf_pkg::OFF_RHR_THR: begin
                  if (lcr7) begin
                     divisor_in = (divisor_ff & ubrf_pkg::DIV_HI_MASK) | {8'h00, write_data};
                  end else begin
                     rsp.tx_valid = 1'b1;
                     rsp.tx_byte  = write_data;
                  end
               end
               ubrf_pkg::OFF_IER: begin
                  if (lcr7) begin
                     divisor_in = (divisor_ff & ubrf_pkg::DIV_LO_MASK) | {write_data, 8'h00};
                  end else begin
                     rsp.access_error = 1'b1;
                  end
               end
               ubrf_pkg::OFF_FCR_EFR: begin
                  if (bank_ff) begin
                     rsp.access_error = |(write_data & ubrf_pkg::EFR_BAD_BITS);
                     efr_in = write_data;
                  end else begin
                     rsp.access_error = |(write_data & ubrf_pkg::FCR_BAD_BITS);
                     fcr_in = write_data;
                  end
               end
               ubrf_pkg::OFF_LCR: begin
                  if (acr7) begin
                     rsp.access_error = 1'b1;
                  end else if (write_data == ubrf_pkg::LCR_BANK_KEY) begin
                     bank_in = 1'b1;
                     lcr_in  = lcr_ff | ubrf_pkg::LCR_DLAB;
                  end else begin
                     bank_in = 1'b0;
                     rsp.access_error = |(write_data & ubrf_pkg::LCR_BAD_BITS);
                     lcr_in  = write_data;
                  end
               end
               ubrf_pkg::OFF_MCR: begin
                  if (bank_ff || acr7) begin
                     rsp.access_error = 1'b1;
                  end else begin
                     rsp.access_error = |(write_data & ubrf_pkg::MCR_BAD_BITS);
                     mcr_in = write_data;
                  end
               end
               ubrf_pkg::OFF_LSR_ICR: begin
                  if (bank_ff) begin
                     rsp.access_error = 1'b1;
                  end else begin
                     ram_we = 1'b1;
                  end
               end
               ubrf_pkg::OFF_SPR: begin
                  if (bank_ff) begin
                     rsp.access_error = 1'b1;
                  end else begin
                     spr_in = write_data;
                  end
               end
               default: begin
                  rsp.access_error = 1'b1;
               end
            endcase
         end else begin
            case (reg_offset)
               ubrf_pkg::OFF_RHR_THR: begin
                  if (lcr7 || !rx_ready) begin
                     rsp.access_error = 1'b1;
                  end else begin
                     rsp.read_data = rx_byte;
                     rsp.rx_take   = 1'b1;
                  end
               end
               ubrf_pkg::OFF_FCR_EFR: begin
                  if (bank_ff) begin
                     rsp.read_data = efr_ff;
                  end else begin
                     rsp.access_error = 1'b1;
                  end
               end
               ubrf_pkg::OFF_LCR: begin
                  if (acr7) begin
                     rsp.access_error = 1'b1;
                  end else begin
                     rsp.read_data = bank_ff ? ubrf_pkg::LCR_BANK_KEY : lcr_ff;
                  end
               end
               ubrf_pkg::OFF_LSR_ICR: begin
                  if (bank_ff || acr7 || acr6) begin
                     rsp.access_error = 1'b1;
                  end else begin
                     rsp.sleep_request = poll_cnt > ubrf_pkg::POLL_LIMIT;
                     poll_in = rx_ready ? '0 : poll_cnt;
                     rsp.read_data = rx_ready ? ubrf_pkg::LSR_RX_READY
                                              : ubrf_pkg::LSR_RX_EMPTY;
                  end
               end
               default: begin
                  rsp.access_error = 1'b1;
               end
            endcase
         end
      end
   end

   assign fwd_valid_in = ram_we && (spr_ff == ubrf_pkg::ACR_INDEX);
   assign acr_valid_in = acr_valid_ff | fwd_valid_in;

   // MCR power-on value follows the clock option: 1 when it is 0, else 0
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_select_ff <= 1'b0;
         divisor_ff      <= 16'd1;
         lcr_ff          <= '0;
         mcr_ff          <= {7'd0, ~clock_select_ff};
         fcr_ff          <= '0;
         efr_ff          <= '0;
         spr_ff          <= '0;
         bank_ff         <= 1'b0;
         poll_ff         <= '0;
         acr_valid_ff    <= 1'b0;
         fwd_valid_ff    <= 1'b0;
      end else begin
         clock_select_ff <= clock_select_in;
         divisor_ff      <= divisor_in;
         lcr_ff          <= lcr_in;
         mcr_ff          <= mcr_in;
         fcr_ff          <= fcr_in;
         efr_ff          <= efr_in;
         spr_ff          <= spr_in;
         bank_ff         <= bank_in;
         poll_ff         <= poll_in;
         acr_valid_ff    <= acr_valid_in;
         fwd_valid_ff    <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= write_data;
   end

endmodule

// ===== sv/ubrf_out.sv =====
`timescale 1ns / 1ps

module ubrf_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              acc,
   input  ubrf_pkg::rsp_type din,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output ubrf_pkg::rsp_type dout
);

   logic              out_v_ff, out_v_in;
   logic              skid_v_ff, skid_v_in;
   ubrf_pkg::rsp_type out_ff, out_in;
   ubrf_pkg::rsp_type skid_ff, skid_in;
   logic              out_free;

   assign out_free = !out_v_ff || out_ready;
   assign in_ready = !skid_v_ff;

   always_comb begin
      out_v_in  = out_v_ff;
      skid_v_in = skid_v_ff;
      out_in    = out_ff;
      skid_in   = skid_ff;
      if (out_free) begin
         if (skid_v_ff) begin
            out_v_in  = 1'b1;
            out_in    = skid_ff;
            skid_v_in = acc;
            skid_in   = din;
         end else begin
            out_v_in  = acc;
            out_in    = din;
         end
      end else if (acc) begin
         skid_v_in = 1'b1;
         skid_in   = din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign out_valid = out_v_ff;
   assign dout      = out_ff;

endmodule

// ===== sv/uart_banked_register_file_unit.sv =====
`timescale 1ns / 1ps

// Register interface of a 16C950-style UART, one bus access per word.
// req_bus: a read or write to one of eight offsets, with the receive byte
//   and its ready flag sampled alongside. rsp_bus: one result word per
//   request (read data, transmit byte, receive take, sleep and error flags).
// csr_bus: clock option write, always ready; the user must have it only
//   written while idle; the block does not enforce this.
// Throughput: one access per cycle while req ready holds; the result word is
//   registered, and register update and decode complete in the accept cycle.
// The indirect array sits in a 256x8 RAM; entry 0 (ACR) is read at a fixed
//   address every cycle, with a forward path covering the RAM read latency
//   and a valid bit giving zero before the first write.
// Reset: all registers to their power-on values, output and skid empty.
// Stall: a two-entry output (register plus skid) keeps taking requests
//   while one result waits; req ready drops only when both are full.
module uart_banked_register_file_unit (
   input  logic           clock,
   input  logic           reset,
   ubrf_req_if.sink       req_bus,
   ubrf_rsp_if.source     rsp_bus,
   ubrf_csr_if.sink       csr_bus
);

   logic              acc;
   logic              in_ready;
   ubrf_pkg::rsp_type core_rsp;
   ubrf_pkg::rsp_type out_rsp;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = in_ready;
   assign acc           = req_bus.valid && in_ready;

   ubrf_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_bus.valid),
      .csr_data   (csr_bus.data),
      .acc        (acc),
      .cmd        (req_bus.cmd),
      .reg_offset (req_bus.reg_offset),
      .write_data (req_bus.write_data),
      .rx_ready   (req_bus.rx_ready),
      .rx_byte    (req_bus.rx_byte),
      .rsp        (core_rsp)
   );

   ubrf_out u_out (
      .clock     (clock),
      .reset     (reset),
      .acc       (acc),
      .din       (core_rsp),
      .in_ready  (in_ready),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .dout      (out_rsp)
   );

   assign rsp_bus.read_data     = out_rsp.read_data;
   assign rsp_bus.tx_valid      = out_rsp.tx_valid;
   assign rsp_bus.tx_byte       = out_rsp.tx_byte;
   assign rsp_bus.rx_take       = out_rsp.rx_take;
   assign rsp_bus.sleep_request = out_rsp.sleep_request;
   assign rsp_bus.access_error  = out_rsp.access_error;

   // back-pressure only with a result already waiting
   a_ready_needs_full: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> rsp_bus.valid)
      else $error("request stalled with empty output");

   // an accepted word into an empty output shows up next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (acc && !rsp_bus.valid) |=> rsp_bus.valid)
      else $error("result word lost");

   // errors never carry data or a transmit
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.access_error) |->
      (rsp_bus.read_data == '0 && !rsp_bus.tx_valid && !rsp_bus.rx_take))
      else $error("error word carries payload");

   // one access cannot both transmit and take a receive byte
   a_tx_rx_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.tx_valid && rsp_bus.rx_take))
      else $error("transmit and receive in one word");

endmodule
